// ===== src/vnop_pkg.sv =====
// Shared constants for the fractal value noise pixel pipeline.
// Holds the permutation table and the fixed-point constants; depends on nothing.
`default_nettype none
package vnop_pkg;
	localparam int OCTAVES   = 4;
	localparam int FRAC_BITS = 16;
	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;

	localparam logic [2:0] REG_SEED  = 3'd0;
	localparam logic [2:0] REG_STEP  = 3'd1;
	localparam logic [2:0] REG_RED   = 3'd2;
	localparam logic [2:0] REG_GREEN = 3'd3;
	localparam logic [2:0] REG_BLUE  = 3'd4;

	localparam logic [8:0]  SEED_RST = 9'd0;
	localparam logic [23:0] STEP_RST = 24'd6554;
	localparam logic [15:0] GAIN_RST = 16'hFFFF;

	localparam int ACC_W  = 24 + OCTAVES;
	localparam int SUM_W  = ACC_W - 8;
	localparam int DIV_D  = (1 << OCTAVES) - 1;
	localparam int DIV_K  = 28;
	localparam logic [24:0] DIV_R = 25'(((64'd1 << DIV_K) + DIV_D - 1) / DIV_D);
	localparam int COL_K  = 12;
	localparam logic [7:0] COL_R = 8'(((1 << COL_K) + 19) / 20);

	localparam logic [7:0] PERM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
		8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
		8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
		8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
		8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
		8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
		8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
		8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
		8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
		8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
		8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
		8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
		8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
		8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
		8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
		8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
		8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
		8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
		8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
		8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
		8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
		8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
		8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
		8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
		8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
		8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
		8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
		8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
	};
endpackage
`default_nettype wire

// ===== src/value_noise_octave_pixel.sv =====
// Fractal value noise pixel pipeline: coordinate products, lattice hashing,
// smoothstep blending, octave sum, divide by constant and colour tinting.
// Depends on vnop_pkg.
//
// Usage: one pixel word (pixel_x, pixel_y) enters on in_valid/in_stall and one
// result word (noise_level and three colour bytes) leaves on out_valid/out_stall.
// A word is taken at a clock edge with valid high and stall low.
// The datapath has ten register stages.
// Throughput is one pixel per cycle: every stage advances together each cycle
// that the output register is empty or being drained.
// When the receiver stalls while a result waits, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Registers on the APB port: 0 seed offset, 4 coordinate step, 8 red gain,
// 12 green gain, 16 blue gain. Write them only while the pipeline is empty.
// Reset clears all valid bits and loads the register defaults (step 6554,
// gains all ones, seed zero); there is no clearing pass.
`default_nettype none
module value_noise_octave_pixel
	import vnop_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [11:0]        pixel_x,
	input  wire logic [11:0]        pixel_y,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             noise_level,
	output logic [7:0]              red_out,
	output logic [7:0]              green_out,
	output logic [7:0]              blue_out,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready
);
	logic [8:0]  seed_q;
	logic [23:0] step_q;
	logic [15:0] red_q, green_q, blue_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q  <= SEED_RST;
			step_q  <= STEP_RST;
			red_q   <= GAIN_RST;
			green_q <= GAIN_RST;
			blue_q  <= GAIN_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_SEED:  seed_q  <= pwdata[8:0];
				REG_STEP:  step_q  <= pwdata[23:0];
				REG_RED:   red_q   <= pwdata[15:0];
				REG_GREEN: green_q <= pwdata[15:0];
				REG_BLUE:  blue_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_SEED:  prdata = {23'd0, seed_q};
			REG_STEP:  prdata = {8'd0, step_q};
			REG_RED:   prdata = {16'd0, red_q};
			REG_GREEN: prdata = {16'd0, green_q};
			REG_BLUE:  prdata = {16'd0, blue_q};
			default:   prdata = '0;
		endcase
	end

	logic pipe_en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	assign pipe_en  = !(v_s10 && out_stall);
	assign in_stall = !pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (pipe_en) begin
			v_s1  <= in_valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// stage 1: coordinate products, only the low 24 bits reach any octave
	logic [35:0] px_full, py_full;
	logic [23:0] px_s1, py_s1;
	assign px_full = 36'(pixel_x) * 36'(step_q);
	assign py_full = 36'(pixel_y) * 36'(step_q);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			px_s1 <= px_full[23:0];
			py_s1 <= py_full[23:0];
		end
	end

	logic [23:0] n_s5 [OCTAVES];

	for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
		logic [15:0] fx, fy;
		logic [7:0]  xi, yi;
		logic [31:0] sqx_full, sqy_full;
		logic [7:0]  xi_s2, row0_s2, row1_s2;
		logic [15:0] fx_s2, fy_s2, sqx_s2, sqy_s2;
		logic [17:0] polyx, polyy;
		logic [33:0] wx_full, wy_full;
		logic [15:0] wx_s3, wy_s3, wy_s4;
		logic [7:0]  c00_s3, c10_s3, c01_s3, c11_s3;
		logic [16:0] omx, omy;
		logic [24:0] lo_full, hi_full;
		logic [23:0] lo_s4, hi_s4;
		logic [41:0] n_full;

		assign fx = 16'(px_s1 << o);
		assign fy = 16'(py_s1 << o);
		assign xi = 8'(px_s1 >> (FRAC_BITS - o));
		assign yi = 8'(py_s1 >> (FRAC_BITS - o));
		assign sqx_full = 32'(fx) * 32'(fx);
		assign sqy_full = 32'(fy) * 32'(fy);

		// stage 2: squares and row hashes
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				fx_s2   <= fx;
				fy_s2   <= fy;
				sqx_s2  <= sqx_full[31:16];
				sqy_s2  <= sqy_full[31:16];
				xi_s2   <= xi;
				row0_s2 <= PERM[8'(yi + seed_q[7:0])];
				row1_s2 <= PERM[8'(yi + 8'd1 + seed_q[7:0])];
			end
		end

		assign polyx   = 18'(3 << FRAC_BITS) - {1'b0, fx_s2, 1'b0};
		assign polyy   = 18'(3 << FRAC_BITS) - {1'b0, fy_s2, 1'b0};
		assign wx_full = 34'(sqx_s2) * 34'(polyx);
		assign wy_full = 34'(sqy_s2) * 34'(polyy);

		// stage 3: smoothstep weights and corner hashes
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				wx_s3  <= wx_full[31:16];
				wy_s3  <= wy_full[31:16];
				c00_s3 <= PERM[8'(row0_s2 + xi_s2)];
				c10_s3 <= PERM[8'(row0_s2 + xi_s2 + 8'd1)];
				c01_s3 <= PERM[8'(row1_s2 + xi_s2)];
				c11_s3 <= PERM[8'(row1_s2 + xi_s2 + 8'd1)];
			end
		end

		assign omx = 17'(1 << FRAC_BITS) - 17'(wx_s3);
		assign lo_full = 25'(c00_s3) * 25'(omx) + 25'(c10_s3) * 25'(wx_s3);
		assign hi_full = 25'(c01_s3) * 25'(omx) + 25'(c11_s3) * 25'(wx_s3);

		// stage 4: x blends, exact
		always_ff @(posedge clk) begin
			if (pipe_en) begin
				lo_s4 <= lo_full[23:0];
				hi_s4 <= hi_full[23:0];
				wy_s4 <= wy_s3;
			end
		end

		assign omy    = 17'(1 << FRAC_BITS) - 17'(wy_s4);
		assign n_full = 42'(lo_s4) * 42'(omy) + 42'(hi_s4) * 42'(wy_s4);

		// stage 5: y blend, truncated
		always_ff @(posedge clk) begin
			if (pipe_en)
				n_s5[o] <= n_full[39:16];
		end
	end

	logic [ACC_W-1:0] acc;
	logic [SUM_W-1:0] sum_s6;

	always_comb begin
		acc = '0;
		for (int o = 0; o < OCTAVES; o++)
			acc = acc + (ACC_W'(n_s5[o]) << (OCTAVES - 1 - o));
	end

	// stage 6: octave sum, low byte drops out of the divide
	always_ff @(posedge clk) begin
		if (pipe_en)
			sum_s6 <= acc[ACC_W-1:8];
	end

	logic [SUM_W+24:0] q_full;
	logic [15:0]       noise_s7, noise_s8, noise_s9, noise_s10;
	assign q_full = (SUM_W+25)'(sum_s6) * (SUM_W+25)'(DIV_R);

	// stage 7: divide by the octave weight total through its reciprocal
	always_ff @(posedge clk) begin
		if (pipe_en)
			noise_s7 <= q_full[DIV_K+15:DIV_K];
	end

	logic [31:0] pr_s8, pg_s8, pb_s8;
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			noise_s8 <= noise_s7;
			pr_s8    <= 32'(red_q) * 32'(noise_s7);
			pg_s8    <= 32'(green_q) * 32'(noise_s7);
			pb_s8    <= 32'(blue_q) * 32'(noise_s7);
		end
	end

	logic [39:0] sr, sg, sb;
	logic [7:0]  vr_s9, vg_s9, vb_s9;
	assign sr = 40'(pr_s8) * 40'd255;
	assign sg = 40'(pg_s8) * 40'd255;
	assign sb = 40'(pb_s8) * 40'd255;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			noise_s9 <= noise_s8;
			vr_s9    <= sr[39:32];
			vg_s9    <= sg[39:32];
			vb_s9    <= sb[39:32];
		end
	end

	logic [15:0] dr, dg, db;
	logic [7:0]  red_s10, green_s10, blue_s10;
	assign dr = 16'(vr_s9) * 16'(COL_R);
	assign dg = 16'(vg_s9) * 16'(COL_R);
	assign db = 16'(vb_s9) * 16'(COL_R);

	// stage 10: divide by twenty, result never exceeds one byte
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			noise_s10 <= noise_s9;
			red_s10   <= 8'(dr >> COL_K);
			green_s10 <= 8'(dg >> COL_K);
			blue_s10  <= 8'(db >> COL_K);
		end
	end

	assign out_valid   = v_s10;
	assign noise_level = noise_s10;
	assign red_out     = red_s10;
	assign green_out   = green_s10;
	assign blue_out    = blue_s10;

`ifndef ASSERT_OFF
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !pipe_en) |=> (v_s1 && $stable(px_s1) && $stable(py_s1)))
		else $error("stage 1 word changed during stall");
	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 |-> (sum_s6 < SUM_W'(DIV_D * 65536)))
		else $error("octave sum out of range");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (red_out <= 8'd12 && green_out <= 8'd12 && blue_out <= 8'd12))
		else $error("colour byte out of range");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_value_noise_octave_pixel.sv =====
// Testbench for the fractal value noise pixel pipeline: random and directed pixels,
// register phases over the APB port, results checked against an in-bench predictor.
// Depends on vnop_pkg and value_noise_octave_pixel.
`default_nettype none

class noise_scoreboard;
	logic [8:0]  seed;
	logic [23:0] step;
	logic [15:0] gain_r, gain_g, gain_b;
	logic [39:0] want_q[$];
	int errors;

	function new();
		seed = vnop_pkg::SEED_RST;
		step = vnop_pkg::STEP_RST;
		gain_r = vnop_pkg::GAIN_RST;
		gain_g = vnop_pkg::GAIN_RST;
		gain_b = vnop_pkg::GAIN_RST;
		errors = 0;
	endfunction

	function automatic logic [63:0] lattice(logic [63:0] xi, logic [63:0] yi);
		logic [7:0] row;
		row = vnop_pkg::PERM[8'(yi + seed)];
		return vnop_pkg::PERM[8'(row + xi)];
	endfunction

	function automatic logic [63:0] fade(logic [63:0] f);
		logic [63:0] sq;
		sq = (f * f) >> 16;
		return (sq * ((64'd3 << 16) - 2 * f)) >> 16;
	endfunction

	function automatic logic [63:0] octave(logic [63:0] px, logic [63:0] py, int o);
		logic [63:0] cx, cy, xi, yi, wx, wy, lo, hi;
		cx = (px * step) << o;
		cy = (py * step) << o;
		xi = (cx >> 16) & 511;
		yi = (cy >> 16) & 511;
		wx = fade(cx & 16'hFFFF);
		wy = fade(cy & 16'hFFFF);
		lo = lattice(xi, yi) * (65536 - wx) + lattice(xi + 1, yi) * wx;
		hi = lattice(xi, yi + 1) * (65536 - wx) + lattice(xi + 1, yi + 1) * wx;
		return (lo * (65536 - wy) + hi * wy) >> 16;
	endfunction

	function automatic logic [7:0] tint(logic [63:0] g, logic [63:0] n);
		logic [63:0] v;
		v = (g * n * 255) / (64'd20 << 32);
		return (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function void note_pixel(logic [11:0] px, logic [11:0] py);
		logic [63:0] acc, n;
		acc = 0;
		for (int i = 0; i < 4; i++)
			acc += octave(px, py, i) << (3 - i);
		n = ((acc << 16) / (64'd15 << 24)) & 16'hFFFF;
		want_q.push_back({n[15:0], tint(gain_r, n), tint(gain_g, n), tint(gain_b, n)});
	endfunction

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	task check_word(logic [15:0] n, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		logic [39:0] w;
		if (want_q.size() == 0) begin
			report("result word with nothing expected");
			return;
		end
		w = want_q.pop_front();
		if (n !== w[39:24]) report($sformatf("noise %h want %h", n, w[39:24]));
		if (r !== w[23:16]) report($sformatf("red %h want %h", r, w[23:16]));
		if (g !== w[15:8]) report($sformatf("green %h want %h", g, w[15:8]));
		if (b !== w[7:0]) report($sformatf("blue %h want %h", b, w[7:0]));
	endtask
endclass

module tb_value_noise_octave_pixel
	import vnop_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, out_valid, out_stall = 0;
	logic [11:0] pixel_x = 0, pixel_y = 0;
	logic [15:0] noise_level;
	logic [7:0] red_out, green_out, blue_out;
	logic psel = 0, penable = 0, pwrite = 0, pready;
	logic [ADDR_W-1:0] paddr = 0;
	logic [DATA_W-1:0] pwdata = 0, prdata;
	int send_idle = 0, stall_pct = 0, hold_off = 0;
	noise_scoreboard sb = new();

	value_noise_octave_pixel DUT (.*);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_word(noise_level, red_out, green_out, blue_out);
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1; pwrite <= 1; paddr <= ADDR_W'(idx * 4); pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_SEED:  sb.seed = val[8:0];
			REG_STEP:  sb.step = val[23:0];
			REG_RED:   sb.gain_r = val[15:0];
			REG_GREEN: sb.gain_g = val[15:0];
			REG_BLUE:  sb.gain_b = val[15:0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(logic [11:0] px, logic [11:0] py);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1; pixel_x <= px; pixel_y <= py;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_pixel(px, py);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.want_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic random_run(int n);
		for (int i = 0; i < n; i++)
			send_pixel(12'($urandom), 12'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(0, 4095);
		send_pixel(4095, 0);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		send_pixel(1, 1);
		drain();
		write_reg(REG_SEED, 511);
		write_reg(REG_STEP, 24'hFFFFFF);
		write_reg(REG_RED, 0);
		write_reg(REG_GREEN, 16'hFFFF);
		write_reg(REG_BLUE, 16'h8000);
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(12'h800, 12'h001);
		send_pixel(7, 4093);
		drain();
		write_reg(REG_STEP, 1);
		send_pixel(4095, 4095);
		send_pixel(100, 3000);
		drain();
		write_reg(REG_STEP, 65536);
		write_reg(REG_SEED, 0);
		send_pixel(255, 256);
		send_pixel(511, 512);
		drain();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_SEED, $urandom_range(511));
			write_reg(REG_STEP, (ph == 5) ? 24'hFFFFFF : $urandom_range(1, 24'hFFFFFF));
			write_reg(REG_RED, $urandom_range(16'hFFFF));
			write_reg(REG_GREEN, (ph == 1) ? 0 : $urandom_range(16'hFFFF));
			write_reg(REG_BLUE, (ph == 2) ? 16'hFFFF : $urandom_range(16'hFFFF));
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 52; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 52; end
				default: begin send_idle = 33; stall_pct = 33; end
			endcase
			if (ph == 3) begin
				send_idle = 0;
				hold_off <= 60;
			end
			random_run(200);
			drain();
		end
		if (sb.errors == 0 && sb.want_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

`default_nettype wire

// ===== filelist.f =====
src/vnop_pkg.sv
src/value_noise_octave_pixel.sv
verif/tb_value_noise_octave_pixel.sv
